### design/ptla_pkg.sv
// shared constants, op codes and types for the page table with lru replacement
// no dependencies
package ptla_pkg;

    localparam int MAX_VPAGES = 1024;
    localparam int MAX_PPAGES = 64;

    localparam int VPN_W   = $clog2(MAX_VPAGES);
    localparam int PPN_W   = $clog2(MAX_PPAGES);
    localparam int LEN_W   = PPN_W + 1;
    localparam int PHYS_W  = 7;
    localparam int VIRT_W  = 11;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = PPN_W + 1;

    localparam logic REG_PHYS = 1'b0;
    localparam logic REG_VIRT = 1'b1;

    localparam logic [1:0] LRU_OP_APPEND = 2'd0;
    localparam logic [1:0] LRU_OP_TOUCH  = 2'd1;
    localparam logic [1:0] LRU_OP_EVICT  = 2'd2;

    typedef struct packed {
        logic [PHYS_W-1:0] nphys;
        logic [VIRT_W-1:0] nvirt;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [VPN_W-1:0] vpn;
        logic [LEN_W-1:0] len;
    } t_lru_cmd;

    typedef struct packed {
        logic             done;
        logic [VPN_W-1:0] victim;
    } t_lru_sts;

endpackage

### design/ptla_cfg.sv
// configuration registers behind the apb-style port, with range limiting
// depends on ptla_pkg
module ptla_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptla_pkg::ADDR_W-1:0]    paddr,
    input  logic [ptla_pkg::DATA_W-1:0]    pwdata,
    output logic [ptla_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output ptla_pkg::t_cfg                 o_cfg
);

    localparam int PW = ptla_pkg::PHYS_W;
    localparam int VW = ptla_pkg::VIRT_W;

    logic [PW-1:0] r_phys_pages;
    logic [VW-1:0] r_virt_pages;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phys_pages <= PW'(ptla_pkg::MAX_PPAGES);
            r_virt_pages <= VW'(ptla_pkg::MAX_VPAGES);
        end else if (wr_en) begin
            if (paddr[2] == ptla_pkg::REG_PHYS) begin
                r_phys_pages <= pwdata[PW-1:0];
            end else begin
                r_virt_pages <= pwdata[VW-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ptla_pkg::REG_VIRT) begin
            prdata = ptla_pkg::DATA_W'(r_virt_pages);
        end else begin
            prdata = ptla_pkg::DATA_W'(r_phys_pages);
        end
    end

    always_comb begin
        if (r_phys_pages == '0) begin
            o_cfg.nphys = PW'(1);
        end else if (r_phys_pages > PW'(ptla_pkg::MAX_PPAGES)) begin
            o_cfg.nphys = PW'(ptla_pkg::MAX_PPAGES);
        end else begin
            o_cfg.nphys = r_phys_pages;
        end
        if (r_virt_pages == '0) begin
            o_cfg.nvirt = VW'(1);
        end else if (r_virt_pages > VW'(ptla_pkg::MAX_VPAGES)) begin
            o_cfg.nvirt = VW'(ptla_pkg::MAX_VPAGES);
        end else begin
            o_cfg.nvirt = r_virt_pages;
        end
    end

endmodule

### design/ptla_lru.sv
// lru order list memory and the walker that searches and compacts it
// each entry is read in L_RD, then compared and moved in L_EX; depends on ptla_pkg
module ptla_lru (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ptla_pkg::t_lru_cmd  i_cmd,
    output ptla_pkg::t_lru_sts  o_sts
);

    localparam int IW = ptla_pkg::PPN_W;
    localparam int LW = ptla_pkg::LEN_W;
    localparam int VW = ptla_pkg::VPN_W;

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_RD   = 2'd1;
    localparam logic [1:0] L_EX   = 2'd2;
    localparam logic [1:0] L_END  = 2'd3;

    logic [VW-1:0] r_mem [ptla_pkg::MAX_PPAGES];
    logic [VW-1:0] r_rdata;
    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [IW-1:0] r_idx;
    logic [LW-1:0] r_len;
    logic [VW-1:0] r_vpn;
    logic [VW-1:0] r_victim;
    logic          r_evict;
    logic          r_found;
    logic          r_done;
    logic          match;
    logic          last;
    logic          we;
    logic [IW-1:0] waddr;
    logic [VW-1:0] wdata;

    assign match = r_evict ? (r_idx == '0) : (!r_found && (r_rdata == r_vpn));
    assign last  = (LW'(r_idx) + LW'(1)) == r_len;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx - IW'(1);
        wdata = r_rdata;
        case (r_state)
            L_IDLE: begin
                if (i_cmd.start && i_cmd.op == ptla_pkg::LRU_OP_APPEND) begin
                    we    = 1'b1;
                    waddr = i_cmd.len[IW-1:0];
                    wdata = i_cmd.vpn;
                end
            end
            L_EX: begin
                we = r_found;
            end
            L_END: begin
                we    = r_found;
                waddr = IW'(r_len - LW'(1));
                wdata = r_vpn;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: begin
                if (i_cmd.start && i_cmd.op != ptla_pkg::LRU_OP_APPEND) begin
                    n_state = (i_cmd.len == '0) ? L_END : L_RD;
                end
            end
            L_RD:    n_state = L_EX;
            L_EX:    n_state = last ? L_END : L_RD;
            L_END:   n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == L_END) ||
                       (r_state == L_IDLE && i_cmd.start &&
                        i_cmd.op == ptla_pkg::LRU_OP_APPEND);
            if (r_state == L_IDLE) begin
                r_found <= 1'b0;
            end else if (r_state == L_EX) begin
                r_found <= r_found || match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == L_IDLE) begin
            r_idx   <= '0;
            r_len   <= i_cmd.len;
            r_vpn   <= i_cmd.vpn;
            r_evict <= (i_cmd.op == ptla_pkg::LRU_OP_EVICT);
        end else if (r_state == L_EX) begin
            r_idx <= r_idx + IW'(1);
            if (r_evict && r_idx == '0) begin
                r_victim <= r_rdata;
            end
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.victim = r_victim;

endmodule

### design/page_table_lru_alloc.sv
// page table with lru replacement: one word in, one translated word out
// an out-of-range page goes straight to the output; a fresh allocation appends to the lru list,
// while a hit or an eviction waits for the lru list walk over the frames in use
// one word at a time; the next word is taken once the current result is registered
// after reset a clearing pass runs over all 1024 page table entries before the
// first word is taken; configuration is reset to 64 frames and 1024 pages
module page_table_lru_alloc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ptla_pkg::VPN_W-1:0]          i_vpn,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ptla_pkg::PPN_W-1:0]          o_ppn,
    output logic                                o_hit,
    output logic                                o_evicted,
    output logic                                o_vpn_error,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptla_pkg::ADDR_W-1:0]         paddr,
    input  logic [ptla_pkg::DATA_W-1:0]         pwdata,
    output logic [ptla_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int VW = ptla_pkg::VPN_W;
    localparam int PW = ptla_pkg::PPN_W;
    localparam int LW = ptla_pkg::LEN_W;
    localparam int EW = ptla_pkg::ENTRY_W;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_PRD  = 4'd2;
    localparam logic [3:0] S_PCHK = 4'd3;
    localparam logic [3:0] S_LWT  = 4'd4;
    localparam logic [3:0] S_VRD  = 4'd5;
    localparam logic [3:0] S_VCHK = 4'd6;
    localparam logic [3:0] S_VWR  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    ptla_pkg::t_cfg     cfg;
    ptla_pkg::t_lru_cmd lru_cmd;
    ptla_pkg::t_lru_sts lru_sts;

    logic [EW-1:0] r_page_mem [ptla_pkg::MAX_VPAGES];
    logic [EW-1:0] r_page_rd;
    logic          page_we;
    logic [VW-1:0] page_waddr;
    logic [EW-1:0] page_wdata;
    logic [VW-1:0] page_raddr;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [VW-1:0] r_clr;
    logic [VW-1:0] r_vpn;
    logic [LW-1:0] r_frames;
    logic [PW-1:0] r_res_ppn;
    logic          r_res_hit;
    logic          r_res_evict;
    logic          r_res_err;
    logic          r_o_valid;
    logic [PW-1:0] r_o_ppn;
    logic          r_o_hit;
    logic          r_o_evicted;
    logic          r_o_err;

    logic          accept;
    logic          in_err;
    logic          pg_valid;
    logic          has_free;
    logic          out_free;

    ptla_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ptla_lru u_lru (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (lru_cmd),
        .o_sts   (lru_sts)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && !o_stall;
    assign in_err   = ptla_pkg::VIRT_W'(i_vpn) >= cfg.nvirt;
    assign pg_valid = r_page_rd[EW-1];
    assign has_free = r_frames < LW'(cfg.nphys);
    assign out_free = !r_o_valid || !i_stall;

    assign page_raddr = (r_state == S_VRD) ? lru_sts.victim : r_vpn;

    always_comb begin
        page_we    = 1'b0;
        page_waddr = r_vpn;
        page_wdata = {1'b1, r_res_ppn};
        case (r_state)
            S_CLR: begin
                page_we    = 1'b1;
                page_waddr = r_clr;
                page_wdata = '0;
            end
            S_PCHK: begin
                page_we    = !pg_valid && has_free;
                page_wdata = {1'b1, r_frames[PW-1:0]};
            end
            S_VCHK: begin
                page_we    = 1'b1;
                page_waddr = lru_sts.victim;
                page_wdata = {1'b0, r_page_rd[PW-1:0]};
            end
            S_VWR: begin
                page_we = 1'b1;
            end
            default: begin
                page_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (page_we) begin
            r_page_mem[page_waddr] <= page_wdata;
        end
        r_page_rd <= r_page_mem[page_raddr];
    end

    always_comb begin
        lru_cmd.start = 1'b0;
        lru_cmd.op    = ptla_pkg::LRU_OP_TOUCH;
        lru_cmd.vpn   = r_vpn;
        lru_cmd.len   = r_frames;
        if (r_state == S_PCHK) begin
            lru_cmd.start = 1'b1;
            if (pg_valid) begin
                lru_cmd.op = ptla_pkg::LRU_OP_TOUCH;
            end else if (has_free) begin
                lru_cmd.op = ptla_pkg::LRU_OP_APPEND;
            end else begin
                lru_cmd.op = ptla_pkg::LRU_OP_EVICT;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:   n_state = (r_clr == {VW{1'b1}}) ? S_IDLE : S_CLR;
            S_IDLE: begin
                if (accept) begin
                    n_state = in_err ? S_OUT : S_PRD;
                end
            end
            S_PRD:   n_state = S_PCHK;
            S_PCHK:  n_state = S_LWT;
            S_LWT: begin
                if (lru_sts.done) begin
                    n_state = r_res_evict ? S_VRD : S_OUT;
                end
            end
            S_VRD:   n_state = S_VCHK;
            S_VCHK:  n_state = S_VWR;
            S_VWR:   n_state = S_OUT;
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_frames  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + VW'(1);
            end
            if (r_state == S_PCHK && !pg_valid && has_free) begin
                r_frames <= r_frames + LW'(1);
            end
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vpn       <= i_vpn;
            r_res_ppn   <= '0;
            r_res_hit   <= 1'b0;
            r_res_evict <= 1'b0;
            r_res_err   <= in_err;
        end
        if (r_state == S_PCHK) begin
            if (pg_valid) begin
                r_res_ppn <= r_page_rd[PW-1:0];
                r_res_hit <= 1'b1;
            end else if (has_free) begin
                r_res_ppn <= r_frames[PW-1:0];
            end else begin
                r_res_evict <= 1'b1;
            end
        end
        if (r_state == S_VCHK) begin
            r_res_ppn <= r_page_rd[PW-1:0];
        end
        if (r_state == S_OUT && out_free) begin
            r_o_ppn     <= r_res_ppn;
            r_o_hit     <= r_res_hit;
            r_o_evicted <= r_res_evict;
            r_o_err     <= r_res_err;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_ppn       = r_o_ppn;
    assign o_hit       = r_o_hit;
    assign o_evicted   = r_o_evicted;
    assign o_vpn_error = r_o_err;

endmodule

### bench/page_table_lru_alloc_tb.sv
`timescale 1ns / 100ps
// testbench for page_table_lru_alloc: a directed table, then random translations over
// several frame and page counts, checked against fixed results or a page table and lru model of its own
// needs ptla_pkg and the page_table_lru_alloc rtl
module page_table_lru_alloc_tb;
    import ptla_pkg::*;

    localparam int IDLE_LIMIT      = 20000;
    localparam int WORDS_PER_PHASE = 60;
    localparam int NUM_PHASES      = 8;
    localparam int PLAN_LEN        = 23;
    localparam int HOLD_CYCLES     = 300;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic [PPN_W-1:0] ppn;
        logic             hit;
        logic             evicted;
        logic             vpn_error;
    } xlat_t;

    typedef struct {
        row_kind_e   kind;
        logic        regsel;
        int unsigned arg;
        bit          typed;
        xlat_t       res;
    } plan_row_t;

    localparam xlat_t NO_XLAT  = '0;
    localparam xlat_t XLAT_ERR = '{ppn: '0, hit: 1'b0, evicted: 1'b0, vpn_error: 1'b1};

    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_WORD, REG_PHYS, 0,    1'b1, '{6'd0, 1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, REG_PHYS, 1023, 1'b1, '{6'd1, 1'b0, 1'b0, 1'b0}},
        '{ROW_WORD, REG_PHYS, 0,    1'b1, '{6'd0, 1'b1, 1'b0, 1'b0}},
        '{ROW_CFG,  REG_VIRT, 1023, 1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 1023, 1'b1, XLAT_ERR},
        '{ROW_CFG,  REG_PHYS, 0,    1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 5,    1'b1, '{6'd1, 1'b0, 1'b1, 1'b0}},
        '{ROW_WORD, REG_PHYS, 0,    1'b1, '{6'd0, 1'b1, 1'b0, 1'b0}},
        '{ROW_WORD, REG_PHYS, 7,    1'b0, NO_XLAT},
        '{ROW_CFG,  REG_PHYS, 127,  1'b0, NO_XLAT},
        '{ROW_CFG,  REG_VIRT, 0,    1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 0,    1'b1, '{6'd0, 1'b1, 1'b0, 1'b0}},
        '{ROW_WORD, REG_PHYS, 1,    1'b1, XLAT_ERR},
        '{ROW_CFG,  REG_VIRT, 2047, 1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 1023, 1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 7,    1'b0, NO_XLAT},
        '{ROW_CFG,  REG_PHYS, 1,    1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 512,  1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 341,  1'b0, NO_XLAT},
        '{ROW_CFG,  REG_PHYS, 64,   1'b0, NO_XLAT},
        '{ROW_CFG,  REG_VIRT, 1024, 1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 682,  1'b0, NO_XLAT},
        '{ROW_WORD, REG_PHYS, 341,  1'b0, NO_XLAT}
    };

    int phase_phys [NUM_PHASES] = '{64, 1, 2, 127, 8, 0, 0, 64};
    int phase_virt [NUM_PHASES] = '{1024, 2047, 16, 1, 100, 0, 40, 1024};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [VPN_W-1:0]   i_vpn;
    logic               o_valid;
    logic               i_stall;
    logic [PPN_W-1:0]   o_ppn;
    logic               o_hit;
    logic               o_evicted;
    logic               o_vpn_error;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic [PHYS_W-1:0]  phys_reg;
    logic [VIRT_W-1:0]  virt_reg;
    bit                 page_on [MAX_VPAGES];
    logic [PPN_W-1:0]   page_ppn [MAX_VPAGES];
    logic [VPN_W-1:0]   lru_list [MAX_PPAGES];
    int                 frames_used;

    xlat_t              expected_xlat [$];
    xlat_t              want;
    logic [VPN_W-1:0]   recent_vpn [$];
    int                 n_bad;
    bit                 hold_req;
    bit                 quiet;

    page_table_lru_alloc uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_phys();
        if (phys_reg == 0) return 1;
        if (phys_reg > MAX_PPAGES) return MAX_PPAGES;
        return int'(phys_reg);
    endfunction

    function automatic int eff_virt();
        if (virt_reg == 0) return 1;
        if (virt_reg > MAX_VPAGES) return MAX_VPAGES;
        return int'(virt_reg);
    endfunction

    // drop the entry at pos and put vpn at the most-recent end
    function automatic void lru_promote(int pos, logic [VPN_W-1:0] vpn);
        for (int i = pos; i + 1 < frames_used; i++)
            lru_list[i] = lru_list[i + 1];
        lru_list[frames_used - 1] = vpn;
    endfunction

    function automatic xlat_t translate_vpn(logic [VPN_W-1:0] vpn);
        xlat_t            r;
        logic [VPN_W-1:0] victim;
        r = '0;
        if (int'(vpn) >= eff_virt()) begin
            r.vpn_error = 1'b1;
            return r;
        end
        if (page_on[vpn]) begin
            r.hit = 1'b1;
            for (int i = 0; i < frames_used; i++) begin
                if (lru_list[i] == vpn) begin
                    lru_promote(i, vpn);
                    break;
                end
            end
        end else if (frames_used < eff_phys()) begin
            page_on[vpn] = 1'b1;
            page_ppn[vpn] = PPN_W'(frames_used);
            lru_list[frames_used] = vpn;
            frames_used++;
        end else begin
            victim = lru_list[0];
            r.evicted = 1'b1;
            page_on[victim] = 1'b0;
            page_on[vpn] = 1'b1;
            page_ppn[vpn] = page_ppn[victim];
            lru_promote(0, vpn);
        end
        r.ppn = page_ppn[vpn];
        return r;
    endfunction

    function automatic void check_field(string name, logic [PPN_W-1:0] want_v,
                                        logic [PPN_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            n_bad++;
        end
    endfunction

    task automatic offer_word(logic [VPN_W-1:0] vpn, bit typed, xlat_t res);
        xlat_t got;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_vpn <= vpn;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        got = translate_vpn(vpn);
        expected_xlat.push_back(typed ? res : got);
    endtask

    task automatic idle_sender();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // waits for the table to drain, writes the register, then reads it back
    task automatic write_reg(logic regsel, int unsigned value);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] kept;
        mask = (regsel == REG_PHYS) ? (1 << PHYS_W) - 1 : (1 << VIRT_W) - 1;
        kept = value & mask;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_xlat.size() != 0) @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {regsel, 2'b00};
        pwdata <= ($urandom() & ~mask) | kept;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (regsel == REG_PHYS) phys_reg = PHYS_W'(kept);
        else virt_reg = VIRT_W'(kept);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== kept) begin
            $display("%0t: register %0d read expected %0h actual %0h",
                     $time, regsel, kept, prdata);
            n_bad++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_xlat.size() == 0) begin
                $display("%0t: unexpected word, expected none actual ppn %0d hit %0d",
                         $time, o_ppn, o_hit);
                n_bad++;
            end else begin
                want = expected_xlat.pop_front();
                check_field("ppn", want.ppn, o_ppn);
                check_field("hit", want.hit, o_hit);
                check_field("evicted", want.evicted, o_evicted);
                check_field("vpn_error", want.vpn_error, o_vpn_error);
            end
        end
    end

    initial begin
        int r;
        int len;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) len = $urandom_range(1, 20);
                else if (r < 90) len = $urandom_range(1, 3);
                else len = $urandom_range(10, 60);
                @(negedge i_clk);
                i_stall <= (r >= 60);
                repeat (len - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int               r;
        int               phys_v;
        int               virt_v;
        int               span;
        logic [VPN_W-1:0] vpn;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_vpn = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        phys_reg = 64;
        virt_reg = 1024;
        frames_used = 0;
        n_bad = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                write_reg(plan[k].regsel, plan[k].arg);
            end else begin
                offer_word(VPN_W'(plan[k].arg), plan[k].typed, plan[k].res);
                idle_sender();
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            phys_v = phase_phys[ph];
            virt_v = phase_virt[ph];
            if (ph == 5) begin
                phys_v = $urandom_range(0, 127);
                virt_v = $urandom_range(0, 2047);
            end
            write_reg(REG_PHYS, phys_v);
            write_reg(REG_VIRT, virt_v);
            quiet = (ph == 2);
            if (ph == 4) hold_req = 1'b1;
            recent_vpn.delete();
            span = eff_virt();
            if (span > 3 * eff_phys() + 2) span = 3 * eff_phys() + 2;
            repeat (WORDS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 55 && recent_vpn.size() > 0)
                    vpn = recent_vpn[$urandom_range(0, recent_vpn.size() - 1)];
                else if (r < 90)
                    vpn = VPN_W'($urandom_range(0, span - 1));
                else
                    vpn = VPN_W'($urandom());
                offer_word(vpn, 1'b0, NO_XLAT);
                recent_vpn.push_back(vpn);
                if (recent_vpn.size() > 24) void'(recent_vpn.pop_front());
                idle_sender();
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_xlat.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_bad == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
